>>> hw/rtl/mwf_pkg.sv
`default_nettype none

package mwf_pkg;

  // coordinate widths follow the 4-bit row and column fields
  localparam int ROW_W  = 4;
  localparam int COL_W  = 4;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  // grid size; coordinates beyond the field range never lie on the grid
  localparam int GRID_ROWS = 16;
  localparam int GRID_COLS = 16;
  localparam int EFF_ROWS  = (GRID_ROWS < 2 ** ROW_W) ? GRID_ROWS : 2 ** ROW_W;
  localparam int EFF_COLS  = (GRID_COLS < 2 ** COL_W) ? GRID_COLS : 2 ** COL_W;

  // configuration port
  localparam int NUM_REGS = 4;
  localparam int PADDR_W  = $clog2(NUM_REGS) + 2;
  localparam int PDATA_W  = 32;

  localparam logic [$clog2(NUM_REGS)-1:0] REG_START_ROW = 2'd0;
  localparam logic [$clog2(NUM_REGS)-1:0] REG_START_COL = 2'd1;
  localparam logic [$clog2(NUM_REGS)-1:0] REG_GOAL_ROW  = 2'd2;
  localparam logic [$clog2(NUM_REGS)-1:0] REG_GOAL_COL  = 2'd3;

  localparam logic [ROW_W-1:0] RST_START_ROW = 4'd4;
  localparam logic [COL_W-1:0] RST_START_COL = 4'd0;
  localparam logic [ROW_W-1:0] RST_GOAL_ROW  = 4'd2;
  localparam logic [COL_W-1:0] RST_GOAL_COL  = 4'd11;

  typedef enum logic [1:0] {
    MARK_OPEN  = 2'd0,
    MARK_WALL  = 2'd1,
    MARK_ONCE  = 2'd2,
    MARK_AGAIN = 2'd3
  } mark_e;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_UP    = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  typedef struct packed {
    logic [ROW_W-1:0] start_row;
    logic [COL_W-1:0] start_col;
    logic [ROW_W-1:0] goal_row;
    logic [COL_W-1:0] goal_col;
  } cfg_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    mark_e             wr_data;
  } mem_req_t;

  // extended coordinates carry a borrow/carry bit that flags leaving the grid
  function automatic logic on_grid(input logic [ROW_W:0] r, input logic [COL_W:0] c);
    return !r[ROW_W] && !c[COL_W] &&
           (r < (ROW_W + 1)'(EFF_ROWS)) && (c < (COL_W + 1)'(EFF_COLS));
  endfunction

  function automatic logic [ROW_W:0] step_row(input logic [ROW_W-1:0] r, input dir_e d);
    logic [ROW_W:0] res;
    case (d)
      DIR_UP:   res = {1'b0, r} - (ROW_W + 1)'(1);
      DIR_DOWN: res = {1'b0, r} + (ROW_W + 1)'(1);
      default:  res = {1'b0, r};
    endcase
    return res;
  endfunction

  function automatic logic [COL_W:0] step_col(input logic [COL_W-1:0] c, input dir_e d);
    logic [COL_W:0] res;
    case (d)
      DIR_RIGHT: res = {1'b0, c} + (COL_W + 1)'(1);
      DIR_LEFT:  res = {1'b0, c} - (COL_W + 1)'(1);
      default:   res = {1'b0, c};
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mwf_in_if.sv
`default_nettype none

interface mwf_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [mwf_pkg::ROW_W-1:0] cell_row;
  logic [mwf_pkg::COL_W-1:0] cell_col;
  logic                     is_wall;

  modport source (output valid, output cmd, output cell_row, output cell_col,
                  output is_wall, input ready);
  modport sink   (input valid, input cmd, input cell_row, input cell_col,
                  input is_wall, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mwf_out_if.sv
`default_nettype none

interface mwf_out_if;
  logic                     valid;
  logic                     ready;
  logic [mwf_pkg::ROW_W-1:0] agent_row;
  logic [mwf_pkg::COL_W-1:0] agent_col;
  logic [1:0]               heading;
  logic [1:0]               cell_mark;
  logic                     moved;
  logic                     done_res;

  modport source (output valid, output agent_row, output agent_col, output heading,
                  output cell_mark, output moved, output done_res, input ready);
  modport sink   (input valid, input agent_row, input agent_col, input heading,
                  input cell_mark, input moved, input done_res, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mwf_cell_mem.sv
`default_nettype none

module mwf_cell_mem (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mwf_pkg::mem_req_t req_i,
  output mwf_pkg::mark_e         rd_mark_o
);

  logic [1:0]                   mem [mwf_pkg::MEM_DEPTH];
  logic [1:0]                   rd_q;
  logic [mwf_pkg::MEM_DEPTH-1:0] valid_q;
  logic                         rd_vld_q;

  // cell storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  // written flags: a cell never written reads as wall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_mark_o = rd_vld_q ? mwf_pkg::mark_e'(rd_q) : mwf_pkg::MARK_WALL;

endmodule

`default_nettype wire

>>> hw/rtl/mwf_cfg_regs.sv
`default_nettype none

module mwf_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mwf_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mwf_pkg::PDATA_W-1:0]  pwdata,
  output logic      [mwf_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output mwf_pkg::cfg_t                     cfg_o
);

  localparam int IDX_W = $clog2(mwf_pkg::NUM_REGS);

  mwf_pkg::cfg_t    cfg_q;
  logic [IDX_W-1:0] idx;
  logic             wr_stb;

  assign idx    = paddr[mwf_pkg::PADDR_W-1:2];
  assign wr_stb = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_row <= mwf_pkg::RST_START_ROW;
      cfg_q.start_col <= mwf_pkg::RST_START_COL;
      cfg_q.goal_row  <= mwf_pkg::RST_GOAL_ROW;
      cfg_q.goal_col  <= mwf_pkg::RST_GOAL_COL;
    end else if (wr_stb) begin
      case (idx)
        mwf_pkg::REG_START_ROW: cfg_q.start_row <= pwdata[mwf_pkg::ROW_W-1:0];
        mwf_pkg::REG_START_COL: cfg_q.start_col <= pwdata[mwf_pkg::COL_W-1:0];
        mwf_pkg::REG_GOAL_ROW:  cfg_q.goal_row  <= pwdata[mwf_pkg::ROW_W-1:0];
        mwf_pkg::REG_GOAL_COL:  cfg_q.goal_col  <= pwdata[mwf_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    case (idx)
      mwf_pkg::REG_START_ROW: prdata = mwf_pkg::PDATA_W'(cfg_q.start_row);
      mwf_pkg::REG_START_COL: prdata = mwf_pkg::PDATA_W'(cfg_q.start_col);
      mwf_pkg::REG_GOAL_ROW:  prdata = mwf_pkg::PDATA_W'(cfg_q.goal_row);
      mwf_pkg::REG_GOAL_COL:  prdata = mwf_pkg::PDATA_W'(cfg_q.goal_col);
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/mwf_seq.sv
`default_nettype none

module mwf_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mwf_pkg::cfg_t  cfg_i,
  mwf_in_if.sink              in_if,
  mwf_out_if.source           out_if,
  output mwf_pkg::mem_req_t   mem_req_o,
  input  wire mwf_pkg::mark_e rd_mark_i
);

  localparam int ROW_W = mwf_pkg::ROW_W;
  localparam int COL_W = mwf_pkg::COL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PROBE,
    S_CHECK,
    S_READ,
    S_MARK
  } state_e;

  state_e            state_q;
  mwf_pkg::cmd_e     cmd_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic              wall_q;
  logic [ROW_W-1:0]  pos_row_q;
  logic [COL_W-1:0]  pos_col_q;
  mwf_pkg::dir_e     head_q;
  logic              reached_q;
  logic              moved_q;
  logic [1:0]        k_q;

  logic              out_valid_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  mwf_pkg::dir_e     out_head_q;
  mwf_pkg::mark_e    out_mark_q;
  logic              out_moved_q;
  logic              out_done_q;

  mwf_pkg::dir_e     nb_dir;
  logic [ROW_W:0]    nb_row;
  logic [COL_W:0]    nb_col;
  logic              nb_on;
  mwf_pkg::mark_e    nb_mark;
  logic              nb_free;
  logic              pos_on;
  logic              out_free;

  // neighbour under test: right turn, straight, left turn, back
  assign nb_dir  = mwf_pkg::dir_e'(2'(head_q + k_q + 2'd3));
  assign nb_row  = mwf_pkg::step_row(pos_row_q, nb_dir);
  assign nb_col  = mwf_pkg::step_col(pos_col_q, nb_dir);
  assign nb_on   = mwf_pkg::on_grid(nb_row, nb_col);
  assign nb_mark = nb_on ? rd_mark_i : mwf_pkg::MARK_WALL;
  assign nb_free = (nb_mark != mwf_pkg::MARK_WALL);
  assign pos_on  = mwf_pkg::on_grid({1'b0, pos_row_q}, {1'b0, pos_col_q});

  assign out_free = !out_valid_q || out_if.ready;

  assign in_if.ready      = (state_q == S_IDLE);
  assign out_if.valid     = out_valid_q;
  assign out_if.agent_row = out_row_q;
  assign out_if.agent_col = out_col_q;
  assign out_if.heading   = out_head_q;
  assign out_if.cell_mark = out_mark_q;
  assign out_if.moved     = out_moved_q;
  assign out_if.done_res  = out_done_q;

  // memory requests; reads and writes fall in different states, so no forwarding
  always_comb begin
    mem_req_o = '0;
    case (state_q)
      S_EXEC: begin
        if (cmd_q == mwf_pkg::CMD_WRITE) begin
          mem_req_o.wr_en   = mwf_pkg::on_grid({1'b0, row_q}, {1'b0, col_q});
          mem_req_o.wr_addr = {row_q, col_q};
          mem_req_o.wr_data = wall_q ? mwf_pkg::MARK_WALL : mwf_pkg::MARK_OPEN;
        end else if (cmd_q == mwf_pkg::CMD_START) begin
          mem_req_o.wr_en   = mwf_pkg::on_grid({1'b0, cfg_i.start_row},
                                               {1'b0, cfg_i.start_col});
          mem_req_o.wr_addr = {cfg_i.start_row, cfg_i.start_col};
          mem_req_o.wr_data = mwf_pkg::MARK_ONCE;
        end
      end
      S_PROBE: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = {nb_row[ROW_W-1:0], nb_col[COL_W-1:0]};
      end
      S_CHECK: begin
        mem_req_o.wr_en   = nb_free;
        mem_req_o.wr_addr = {nb_row[ROW_W-1:0], nb_col[COL_W-1:0]};
        mem_req_o.wr_data = (nb_mark == mwf_pkg::MARK_OPEN) ? mwf_pkg::MARK_ONCE
                                                            : mwf_pkg::MARK_AGAIN;
      end
      S_READ: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = {pos_row_q, pos_col_q};
      end
      default: ;
    endcase
  end

  // command sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= mwf_pkg::CMD_NONE;
      row_q       <= '0;
      col_q       <= '0;
      wall_q      <= 1'b0;
      pos_row_q   <= '0;
      pos_col_q   <= '0;
      head_q      <= mwf_pkg::DIR_RIGHT;
      reached_q   <= 1'b0;
      moved_q     <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_head_q  <= mwf_pkg::DIR_RIGHT;
      out_mark_q  <= mwf_pkg::MARK_WALL;
      out_moved_q <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      // result taken; a new one loaded in S_MARK takes its place instead
      if (out_valid_q && out_if.ready && (state_q != S_MARK)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_if.valid) begin
            cmd_q   <= mwf_pkg::cmd_e'(in_if.cmd);
            row_q   <= in_if.cell_row;
            col_q   <= in_if.cell_col;
            wall_q  <= in_if.is_wall;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          moved_q <= 1'b0;
          k_q     <= '0;
          case (cmd_q)
            mwf_pkg::CMD_WRITE: state_q <= S_READ;
            mwf_pkg::CMD_START: begin
              pos_row_q <= cfg_i.start_row;
              pos_col_q <= cfg_i.start_col;
              head_q    <= mwf_pkg::DIR_RIGHT;
              reached_q <= (cfg_i.start_row == cfg_i.goal_row) &&
                           (cfg_i.start_col == cfg_i.goal_col);
              state_q   <= S_READ;
            end
            mwf_pkg::CMD_STEP: state_q <= reached_q ? S_READ : S_PROBE;
            default:           state_q <= S_IDLE;
          endcase
        end
        S_PROBE: state_q <= S_CHECK;
        S_CHECK: begin
          if (nb_free) begin
            pos_row_q <= nb_row[ROW_W-1:0];
            pos_col_q <= nb_col[COL_W-1:0];
            head_q    <= nb_dir;
            moved_q   <= 1'b1;
            reached_q <= (nb_row[ROW_W-1:0] == cfg_i.goal_row) &&
                         (nb_col[COL_W-1:0] == cfg_i.goal_col);
            state_q   <= S_READ;
          end else if (k_q == 2'd3) begin
            // boxed in: nothing changes
            state_q <= S_READ;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_PROBE;
          end
        end
        S_READ: state_q <= S_MARK;
        S_MARK: begin
          // hold here until the result slot frees up
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_row_q   <= pos_row_q;
            out_col_q   <= pos_col_q;
            out_head_q  <= head_q;
            out_mark_q  <= pos_on ? rd_mark_i : mwf_pkg::MARK_WALL;
            out_moved_q <= moved_q;
            out_done_q  <= reached_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/maze_wall_follower_core.sv
// Right-hand wall follower over a 16 x 16 grid of 2-bit cell marks.
// Input channel (in_if): one word per command. cmd 0 writes a cell (wall or
// open), cmd 1 places the agent on the start cell facing right, cmd 2 takes
// one step; cmd 3 is dropped and gives no result.
// Output channel (out_if): one word per cmd 0/1/2 with agent position,
// heading, the mark on the agent's cell, a moved flag and the done flag.
// Start and goal cells sit in four registers on the APB-style port at byte
// addresses 0, 4, 8 and 12; write them only while the block is idle.
// A step probes one to four neighbours, or none when the goal is already
// reached. Each probe is a read of the cell memory followed by a decision;
// the decision that finds a free neighbour also writes its visit mark, and
// a read-back of the agent's cell follows. One command is in flight at a
// time; in_if.ready is high only while the sequencer is idle, so a new
// command is taken only after the last one has finished.
// Reset makes every cell a wall (per-cell written flags), puts the agent at
// row 0, column 0 facing right and loads the register defaults.
// A stalled receiver holds the result; the next command is still taken and
// runs up to its result, which waits until the pending word is taken.
`default_nettype none

module maze_wall_follower_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  mwf_in_if.sink                            in_if,
  mwf_out_if.source                         out_if,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mwf_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mwf_pkg::PDATA_W-1:0]  pwdata,
  output logic      [mwf_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);

  mwf_pkg::cfg_t     cfg;
  mwf_pkg::mem_req_t mem_req;
  mwf_pkg::mark_e    rd_mark;

  // configuration registers
  mwf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // cell memory
  mwf_cell_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_mark_o (rd_mark)
  );

  // command sequencer
  mwf_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_if     (in_if),
    .out_if    (out_if),
    .mem_req_o (mem_req),
    .rd_mark_i (rd_mark)
  );

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("command taken while the previous one is in flight");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.rd_en && mem_req.wr_en))
    else $error("cell read and write issued in the same cycle");

  a_moved_marks_visit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.moved) |->
      (out_if.cell_mark == mwf_pkg::MARK_ONCE || out_if.cell_mark == mwf_pkg::MARK_AGAIN))
    else $error("agent moved onto a cell without a visit mark");

  a_done_on_goal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.moved && out_if.done_res) |->
      (out_if.agent_row == cfg.goal_row && out_if.agent_col == cfg.goal_col))
    else $error("done set by a step that did not land on the goal");

endmodule

`default_nettype wire
